### rtl/cdwf_pkg.sv
// Shared types and constants for the dual-window current fault block.
`default_nettype none

package cdwf_pkg;

  // Fixed widths of the item fields and of the limit registers.
  localparam int CHAN_W    = 2;
  localparam int SAMPLE_W  = 16;
  localparam int LIMIT_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int REG_IDX_W = 2;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Channel status codes.
  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_WARN_UNDER  = 3'd1;
  localparam status_t ST_WARN_OVER   = 3'd2;
  localparam status_t ST_FAULT_UNDER = 3'd3;
  localparam status_t ST_FAULT_OVER  = 3'd4;

  // Configuration register indexes.
  localparam reg_idx_t REG_SLOW_UNDER = 2'd0;
  localparam reg_idx_t REG_SLOW_OVER  = 2'd1;
  localparam reg_idx_t REG_FAST_UNDER = 2'd2;
  localparam reg_idx_t REG_FAST_OVER  = 2'd3;

  // Reset values of the limit registers.
  localparam logic signed [LIMIT_W-1:0] SLOW_UNDER_RST = -16'sd2500;
  localparam logic signed [LIMIT_W-1:0] SLOW_OVER_RST  = 16'sd2500;
  localparam logic signed [LIMIT_W-1:0] FAST_UNDER_RST = -16'sd3000;
  localparam logic signed [LIMIT_W-1:0] FAST_OVER_RST  = 16'sd3000;

endpackage

`default_nettype wire

### rtl/cdwf_sample_if.sv
// Input channel carrying one current sample item per handshake.
`default_nettype none

interface cdwf_sample_if
  import cdwf_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          channel;
  logic signed [SAMPLE_W-1:0] current_sample;
  logic                       sensor_ready;

  modport source (output valid, output channel, output current_sample,
                  output sensor_ready, input ready);
  modport sink   (input valid, input channel, input current_sample,
                  input sensor_ready, output ready);
endinterface

`default_nettype wire

### rtl/cdwf_result_if.sv
// Output channel carrying one status result item per handshake.
`default_nettype none

interface cdwf_result_if
  import cdwf_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t channel_status;
  logic    trip;
  logic    evaluated;

  modport source (output valid, output channel_status, output trip,
                  output evaluated, input ready);
  modport sink   (input valid, input channel_status, input trip,
                  input evaluated, output ready);
endinterface

`default_nettype wire

### rtl/current_dual_window_fault.sv
// Per-channel current supervision with a slow and a fast averaging window.
// A sample item passes through the sample stage and then the result register.
// One item per cycle unless results stall; the single sample stage does the whole update.
// The result register lets a new item enter while a finished result waits.
// Reset (rst, synchronous, active high) clears all windows, sets every status
// to ok and loads the default limits; no clearing pass is needed.
`default_nettype none

module current_dual_window_fault
  import cdwf_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int SLOW_WINDOW = 20,
  parameter int FAST_WINDOW = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                write_en,
  input  wire logic [REG_IDX_W-1:0] reg_index,
  input  wire logic [LIMIT_W-1:0]  write_data,
  cdwf_sample_if.sink              samples,
  cdwf_result_if.source            results
);

  // Index width for the per-channel state, and window storage widths. A
  // window holds at most WINDOW-1 samples between verdicts, so the counter
  // needs clog2(WINDOW) bits and the sum clog2(WINDOW) bits of growth.
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHN_CMP_W  = 5;
  localparam int SLOW_CNT_W = $clog2(SLOW_WINDOW);
  localparam int FAST_CNT_W = $clog2(FAST_WINDOW);
  localparam int SLOW_SUM_W = SAMPLE_W + $clog2(SLOW_WINDOW);
  localparam int FAST_SUM_W = SAMPLE_W + $clog2(FAST_WINDOW);
  // Compare width: holds both the window sum and limit times window length.
  localparam int SLOW_JW    = SLOW_SUM_W + 2;
  localparam int FAST_JW    = FAST_SUM_W + 2;

  // ---------------------------------------------------------------------
  // Limit registers. They are to be written only while the block is idle; the block does not enforce this.
  // ---------------------------------------------------------------------
  logic signed [LIMIT_W-1:0] slow_under_limit;
  logic signed [LIMIT_W-1:0] slow_over_limit;
  logic signed [LIMIT_W-1:0] fast_under_limit;
  logic signed [LIMIT_W-1:0] fast_over_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_under_limit <= SLOW_UNDER_RST;
      slow_over_limit  <= SLOW_OVER_RST;
      fast_under_limit <= FAST_UNDER_RST;
      fast_over_limit  <= FAST_OVER_RST;
    end else if (write_en) begin
      case (reg_index)
        REG_SLOW_UNDER: slow_under_limit <= write_data;
        REG_SLOW_OVER:  slow_over_limit  <= write_data;
        REG_FAST_UNDER: fast_under_limit <= write_data;
        REG_FAST_OVER:  fast_over_limit  <= write_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. The sample stage holds one accepted item; it moves into the
  // result register whenever that register is empty or being drained. The
  // state update happens on that same edge, so the next item in the sample
  // stage always sees the state left by the item ahead of it.
  // ---------------------------------------------------------------------
  logic                       stage_valid;
  logic [CHAN_W-1:0]          stage_channel;
  logic signed [SAMPLE_W-1:0] stage_sample;
  logic                       stage_sensor_ready;
  logic                       out_valid;
  logic                       advance;

  assign advance       = !out_valid || results.ready;
  assign samples.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (samples.ready) begin
      stage_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      stage_channel      <= samples.channel;
      stage_sample       <= samples.current_sample;
      stage_sensor_ready <= samples.sensor_ready;
    end
  end

  // ---------------------------------------------------------------------
  // Per-channel state.
  // ---------------------------------------------------------------------
  status_t                      status      [CHANNELS];
  status_t                      status_next [CHANNELS];
  logic signed [SLOW_SUM_W-1:0] slow_sum    [CHANNELS];
  logic [SLOW_CNT_W-1:0]        slow_count  [CHANNELS];
  logic signed [FAST_SUM_W-1:0] fast_sum    [CHANNELS];
  logic [FAST_CNT_W-1:0]        fast_count  [CHANNELS];

  // ---------------------------------------------------------------------
  // Sample stage logic: band check, window accumulation and verdicts.
  // ---------------------------------------------------------------------
  logic [CH_W-1:0] idx;
  logic            chan_ok;
  logic            is_under;
  logic            is_over;
  logic            update;

  assign idx      = CH_W'(stage_channel);
  assign chan_ok  = CHN_CMP_W'(stage_channel) < CHN_CMP_W'(CHANNELS);
  // A sample equal to a limit counts as in band.
  assign is_under = stage_sample < slow_under_limit;
  assign is_over  = stage_sample > slow_over_limit;
  assign update   = stage_valid && advance && chan_ok && stage_sensor_ready &&
                    (is_under || is_over);

  logic signed [SLOW_SUM_W-1:0] slow_sum_new;
  logic signed [FAST_SUM_W-1:0] fast_sum_new;
  logic [SLOW_CNT_W:0]          slow_cnt_inc;
  logic [FAST_CNT_W:0]          fast_cnt_inc;
  logic                         slow_full;
  logic                         fast_full;

  assign slow_sum_new = slow_sum[idx] + SLOW_SUM_W'(stage_sample);
  assign fast_sum_new = fast_sum[idx] + FAST_SUM_W'(stage_sample);
  assign slow_cnt_inc = {1'b0, slow_count[idx]} + 1'b1;
  assign fast_cnt_inc = {1'b0, fast_count[idx]} + 1'b1;
  assign slow_full    = slow_cnt_inc == (SLOW_CNT_W + 1)'(SLOW_WINDOW);
  assign fast_full    = fast_cnt_inc == (FAST_CNT_W + 1)'(FAST_WINDOW);

  // The average is judged exactly: the sum is compared with limit times
  // window length, both sign-extended to a width that holds either.
  logic signed [SLOW_JW-1:0] slow_len;
  logic signed [SLOW_JW-1:0] slow_under_scaled;
  logic signed [SLOW_JW-1:0] slow_over_scaled;
  logic signed [SLOW_JW-1:0] slow_sum_ext;
  logic signed [FAST_JW-1:0] fast_len;
  logic signed [FAST_JW-1:0] fast_under_scaled;
  logic signed [FAST_JW-1:0] fast_over_scaled;
  logic signed [FAST_JW-1:0] fast_sum_ext;

  assign slow_len          = SLOW_JW'(SLOW_WINDOW);
  assign fast_len          = FAST_JW'(FAST_WINDOW);
  assign slow_under_scaled = SLOW_JW'(slow_under_limit) * slow_len;
  assign slow_over_scaled  = SLOW_JW'(slow_over_limit) * slow_len;
  assign fast_under_scaled = FAST_JW'(fast_under_limit) * fast_len;
  assign fast_over_scaled  = FAST_JW'(fast_over_limit) * fast_len;
  assign slow_sum_ext      = SLOW_JW'(slow_sum_new);
  assign fast_sum_ext      = FAST_JW'(fast_sum_new);

  status_t slow_verdict;
  status_t fast_verdict;
  status_t new_status;

  always_comb begin
    if (slow_sum_ext < slow_under_scaled) begin
      slow_verdict = ST_FAULT_UNDER;
    end else if (slow_sum_ext > slow_over_scaled) begin
      slow_verdict = ST_FAULT_OVER;
    end else begin
      slow_verdict = ST_OK;
    end
    if (fast_sum_ext < fast_under_scaled) begin
      fast_verdict = ST_FAULT_UNDER;
    end else if (fast_sum_ext > fast_over_scaled) begin
      fast_verdict = ST_FAULT_OVER;
    end else begin
      fast_verdict = ST_OK;
    end
    // The warning comes first; a slow verdict replaces it, and a fast
    // verdict in the same item overrides the slow one.
    if (fast_full) begin
      new_status = fast_verdict;
    end else if (slow_full) begin
      new_status = slow_verdict;
    end else if (is_under) begin
      new_status = ST_WARN_UNDER;
    end else begin
      new_status = ST_WARN_OVER;
    end
  end

  // Status table as it stands after this item, used both for the register
  // update and for the trip flag reported with the result.
  logic trip_next;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      status_next[i] = status[i];
    end
    if (update) begin
      status_next[idx] = new_status;
    end
    trip_next = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (status_next[i] == ST_FAULT_UNDER || status_next[i] == ST_FAULT_OVER) begin
        trip_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        status[i]     <= ST_OK;
        slow_sum[i]   <= '0;
        slow_count[i] <= '0;
        fast_sum[i]   <= '0;
        fast_count[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        status[i] <= status_next[i];
      end
      if (update) begin
        // A full window is judged above and then starts over empty.
        slow_sum[idx]   <= slow_full ? '0 : slow_sum_new;
        slow_count[idx] <= slow_full ? '0 : slow_cnt_inc[SLOW_CNT_W-1:0];
        fast_sum[idx]   <= fast_full ? '0 : fast_sum_new;
        fast_count[idx] <= fast_full ? '0 : fast_cnt_inc[FAST_CNT_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register. A channel outside the configured count reports ok and
  // not evaluated; a skipped sample reports the stored status.
  // ---------------------------------------------------------------------
  status_t out_status;
  logic    out_trip;
  logic    out_evaluated;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      out_status    <= chan_ok ? status_next[idx] : ST_OK;
      out_trip      <= trip_next;
      out_evaluated <= chan_ok && stage_sensor_ready;
    end
  end

  assign results.valid          = out_valid;
  assign results.channel_status = out_status;
  assign results.trip           = out_trip;
  assign results.evaluated      = out_evaluated;

  // Health flags for the checks below.
  logic counts_in_range;
  logic status_legal;

  always_comb begin
    counts_in_range = 1'b1;
    status_legal    = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((SLOW_CNT_W + 1)'(slow_count[i]) >= (SLOW_CNT_W + 1)'(SLOW_WINDOW) ||
          (FAST_CNT_W + 1)'(fast_count[i]) >= (FAST_CNT_W + 1)'(FAST_WINDOW)) begin
        counts_in_range = 1'b0;
      end
      if (status[i] > ST_FAULT_OVER) begin
        status_legal = 1'b0;
      end
    end
  end

`ifndef SYNTH
  // A reported fault status always comes with trip set.
  a_fault_trips: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.channel_status == ST_FAULT_UNDER ||
                      results.channel_status == ST_FAULT_OVER) |-> results.trip)
    else $error("fault status reported without trip");

  // A window never holds its full length between items.
  a_counts: assert property (@(posedge clk) disable iff (rst) counts_in_range)
    else $error("window count reached its length");

  // Only defined status codes are ever stored.
  a_status: assert property (@(posedge clk) disable iff (rst) status_legal)
    else $error("illegal channel status stored");

  // An item held in the sample stage while the result side stalls keeps
  // its payload and stays in place.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_channel) &&
                               $stable(stage_sample))
    else $error("sample stage lost a stalled item");
`endif

endmodule

`default_nettype wire

### dv/tb_current_dual_window_fault.sv
// Self-checking testbench for the dual-window current fault block.
module tb_current_dual_window_fault;
  import cdwf_pkg::*;

  // Block configuration under test, kept equal to the instance parameters.
  localparam int NUM_CH   = 4;
  localparam int SLOW_LEN = 20;
  localparam int FAST_LEN = 6;

  // Margin waited after the last expected result has come back, before any
  // limit is rewritten.
  localparam int SETTLE_CYCLES = 4;
  // Length of the one long back-pressure stretch on the result side.
  localparam int HOLD_CYCLES   = 80;
  // Cycles without any item moving on either side before the run is declared hung.
  localparam int STALL_LIMIT   = 1000;

  // One result item as the block reports it.
  typedef struct packed {
    status_t status;
    logic    trip;
    logic    evaluated;
  } status_item_t;

  // Scoreboard: keeps its own copy of the limits and of every channel's windows,
  // predicts the result of each accepted sample and checks results in order.
  class window_scoreboard;
    int           slow_under, slow_over, fast_under, fast_over;
    status_t      chan_state [NUM_CH];
    longint       slow_sum   [NUM_CH];
    longint       fast_sum   [NUM_CH];
    int           slow_cnt   [NUM_CH];
    int           fast_cnt   [NUM_CH];
    status_item_t expected_q [$];
    int           errors;

    function new();
      slow_under = int'(SLOW_UNDER_RST);
      slow_over  = int'(SLOW_OVER_RST);
      fast_under = int'(FAST_UNDER_RST);
      fast_over  = int'(FAST_OVER_RST);
      foreach (chan_state[i]) begin
        chan_state[i] = ST_OK;
        slow_sum[i]   = 0;
        fast_sum[i]   = 0;
        slow_cnt[i]   = 0;
        fast_cnt[i]   = 0;
      end
      errors = 0;
    endfunction

    function void set_limit(reg_idx_t idx, logic [LIMIT_W-1:0] value);
      int v;
      v = int'(signed'(value));
      case (idx)
        REG_SLOW_UNDER: slow_under = v;
        REG_SLOW_OVER:  slow_over  = v;
        REG_FAST_UNDER: fast_under = v;
        REG_FAST_OVER:  fast_over  = v;
        default: ;
      endcase
    endfunction

    // A sample counts toward the windows only when it leaves the slow band.
    function bit outside(int s);
      return (s < slow_under) || (s > slow_over);
    endfunction

    function bit trip_now();
      foreach (chan_state[i])
        if (chan_state[i] == ST_FAULT_UNDER || chan_state[i] == ST_FAULT_OVER) return 1'b1;
      return 1'b0;
    endfunction

    // The average is judged without division: the sum against limit times length.
    function status_t judge(longint sum, int under, int over, int len);
      if (sum < longint'(under) * len) return ST_FAULT_UNDER;
      if (sum > longint'(over) * len) return ST_FAULT_OVER;
      return ST_OK;
    endfunction

    // Notes an accepted sample; returns 1 when it changed the channel's windows.
    function bit note_sample(int ch, int s, bit rdy);
      status_item_t exp_item;
      bit           took;
      took = 1'b0;
      if (ch >= NUM_CH) begin
        exp_item = '{status: ST_OK, trip: trip_now(), evaluated: 1'b0};
      end else if (!rdy) begin
        exp_item = '{status: chan_state[ch], trip: trip_now(), evaluated: 1'b0};
      end else begin
        if (outside(s)) begin
          took = 1'b1;
          chan_state[ch] = (s < slow_under) ? ST_WARN_UNDER : ST_WARN_OVER;
          slow_sum[ch] += s;
          fast_sum[ch] += s;
          slow_cnt[ch]++;
          fast_cnt[ch]++;
          // The slow verdict comes first so that a fast verdict in the same
          // item overrides it.
          if (slow_cnt[ch] >= SLOW_LEN) begin
            chan_state[ch] = judge(slow_sum[ch], slow_under, slow_over, SLOW_LEN);
            slow_sum[ch]   = 0;
            slow_cnt[ch]   = 0;
          end
          if (fast_cnt[ch] >= FAST_LEN) begin
            chan_state[ch] = judge(fast_sum[ch], fast_under, fast_over, FAST_LEN);
            fast_sum[ch]   = 0;
            fast_cnt[ch]   = 0;
          end
        end
        exp_item = '{status: chan_state[ch], trip: trip_now(), evaluated: 1'b1};
      end
      expected_q.push_back(exp_item);
      return took;
    endfunction

    function void check_result(status_item_t got);
      status_item_t want;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: channel_status=%0d trip=%0b evaluated=%0b",
               got.status, got.trip, got.evaluated);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("channel_status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.trip !== want.trip) begin
        $error("trip mismatch: expected %0b, actual %0b", want.trip, got.trip);
        errors++;
      end
      if (got.evaluated !== want.evaluated) begin
        $error("evaluated mismatch: expected %0b, actual %0b", want.evaluated, got.evaluated);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 write_en;
  logic [REG_IDX_W-1:0] reg_index;
  logic [LIMIT_W-1:0]   write_data;

  cdwf_sample_if samples ();
  cdwf_result_if results ();

  window_scoreboard sb = new();

  // Random idling on either side can be switched off for a stretch of the run.
  bit sender_gaps;
  bit receiver_gaps;
  // Raised once by the stimulus to ask the result side for a long hold-off.
  bit hold_request;
  // Number of accepted samples that moved some channel's windows.
  int active_items;
  // Cycles in a row in which no item was accepted on either side.
  int quiet_cycles;

  current_dual_window_fault #(
    .CHANNELS    (NUM_CH),
    .SLOW_WINDOW (SLOW_LEN),
    .FAST_WINDOW (FAST_LEN)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .samples    (samples),
    .results    (results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one sample item and holds it until the block takes it. Now and then
  // the sender pauses before the item, so gaps land on every
  // phase of the block's work.
  task automatic send_sample(input int ch, input int s, input bit rdy);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(99) < 5) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid          <= 1'b1;
    samples.channel        <= ch[CHAN_W-1:0];
    samples.current_sample <= s[SAMPLE_W-1:0];
    samples.sensor_ready   <= rdy;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    if (sb.note_sample(ch, s, rdy)) active_items++;
  endtask

  // Waits until every expected result has come back and the pipeline is empty.
  task automatic drain();
    samples.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Loads all four limits while the block is idle. The write enable stays high
  // across the four back-to-back writes and drops after the last one.
  task automatic apply_limits(input int su, input int so, input int fu, input int fo);
    reg_idx_t idx [4];
    int       val [4];
    idx = '{REG_SLOW_UNDER, REG_SLOW_OVER, REG_FAST_UNDER, REG_FAST_OVER};
    val = '{su, so, fu, fo};
    drain();
    foreach (idx[i]) begin
      write_en   <= 1'b1;
      reg_index  <= idx[i];
      write_data <= val[i][LIMIT_W-1:0];
      @(posedge clk);
      sb.set_limit(idx[i], val[i][LIMIT_W-1:0]);
    end
    write_en <= 1'b0;
  endtask

  // Picks a sample outside the slow band, half the time close to the bound.
  // When the band covers every possible sample, there is none, and zero is given.
  function automatic int oob_sample();
    int below, above, reach;
    below = sb.slow_under + 32768;
    above = 32767 - sb.slow_over;
    if (below <= 0 && above <= 0) return 0;
    if (above <= 0 || (below > 0 && $urandom_range(1) == 1)) begin
      reach = (below < 3000) ? below : 3000;
      if ($urandom_range(1) == 1) return sb.slow_under - 1 - int'($urandom_range(0, reach - 1));
      return -32768 + int'($urandom_range(0, below - 1));
    end
    reach = (above < 3000) ? above : 3000;
    if ($urandom_range(1) == 1) return sb.slow_over + 1 + int'($urandom_range(0, reach - 1));
    return 32767 - int'($urandom_range(0, above - 1));
  endfunction

  // Random traffic until the given number of samples has moved some window or
  // a cap on the samples sent is reached. Most of it is runs of out-of-band
  // samples that close a window with a sum steered onto a limit or just beside
  // it, since only full windows reach the fault verdicts. The rest is single
  // warnings, in-band samples, samples with the sensor not ready, and raw noise.
  task automatic run_random(input int goal);
    int     start, sent, ch, pick, off, need, tries, v;
    longint target, acc, rest;
    bit     fast_side, planned;
    int     burst [$];
    start = active_items;
    sent  = 0;
    while (active_items - start < goal && sent < 3 * goal + 20) begin
      pick = $urandom_range(99);
      ch   = $urandom_range(NUM_CH - 1);
      if (pick < 55) begin
        fast_side = $urandom_range(1);
        case ($urandom_range(3))
          0: off = 0;
          1: off = -1;
          2: off = 1;
          default: off = int'($urandom_range(0, 4000)) - 2000;
        endcase
        if (fast_side) begin
          need   = FAST_LEN - sb.fast_cnt[ch];
          target = longint'($urandom_range(1) ? sb.fast_over : sb.fast_under) * FAST_LEN
                   - sb.fast_sum[ch] + off;
        end else begin
          need   = SLOW_LEN - sb.slow_cnt[ch];
          target = longint'($urandom_range(1) ? sb.slow_over : sb.slow_under) * SLOW_LEN
                   - sb.slow_sum[ch] + off;
        end
        // Each sample aims at the average still needed, with some jitter; the
        // last one makes up the exact remainder and must itself be out of band.
        planned = 1'b0;
        for (tries = 0; tries < 40 && !planned; tries++) begin
          burst.delete();
          acc = 0;
          for (int i = 0; i < need - 1; i++) begin
            v = int'((target - acc) / (need - i)) + int'($urandom_range(0, 6000)) - 3000;
            if (v < -32768 || v > 32767 || !sb.outside(v)) v = oob_sample();
            burst.push_back(v);
            acc += v;
          end
          rest    = target - acc;
          planned = rest >= -32768 && rest <= 32767 && sb.outside(int'(rest));
          if (planned) burst.push_back(int'(rest));
        end
        if (!planned) burst.delete();
        foreach (burst[i]) send_sample(ch, burst[i], 1'b1);
        sent += burst.size() + 1;
      end else if (pick < 70) begin
        send_sample(ch, oob_sample(), 1'b1);
        sent++;
      end else if (pick < 85) begin
        // In band, often sitting exactly on a limit.
        if (sb.slow_under > sb.slow_over) begin
          v = sb.slow_under;
        end else begin
          case ($urandom_range(3))
            0: v = sb.slow_under;
            1: v = sb.slow_over;
            default: v = sb.slow_under + int'($urandom_range(0, sb.slow_over - sb.slow_under));
          endcase
        end
        send_sample(ch, v, 1'b1);
        sent++;
      end else if (pick < 95) begin
        send_sample(ch, int'($urandom_range(0, 65535)) - 32768, 1'b0);
        sent++;
      end else begin
        send_sample(ch, int'($urandom_range(0, 65535)) - 32768, $urandom_range(1));
        sent++;
      end
    end
  endtask

  // Result side: checks every item taken at an edge, then decides whether to
  // take the next one. A hold request starts a long stretch with ready low,
  // counted here, while the sender keeps offering samples.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && results.valid && results.ready)
        sb.check_result('{status: results.channel_status, trip: results.trip,
                          evaluated: results.evaluated});
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= !(receiver_gaps && $urandom_range(99) < 12);
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clk                    = 1'b0;
    rst                    = 1'b1;
    write_en               = 1'b0;
    reg_index              = REG_SLOW_UNDER;
    write_data             = '0;
    samples.valid          = 1'b0;
    samples.channel        = '0;
    samples.current_sample = '0;
    samples.sensor_ready   = 1'b0;
    results.ready          = 1'b0;
    sender_gaps            = 1'b1;
    receiver_gaps          = 1'b1;
    hold_request           = 1'b0;
    active_items           = 0;
    quiet_cycles           = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset limits. A skipped sample reports the
    // stored status, full-scale samples raise warnings, and samples sitting
    // exactly on the slow limits stay in band.
    send_sample(0, -32768, 1'b0);
    send_sample(1, 32767, 1'b1);
    send_sample(2, -32768, 1'b1);
    send_sample(3, 2500, 1'b1);
    send_sample(3, -2500, 1'b1);
    send_sample(3, 0, 1'b0);
    // A fast window whose average equals the fast over limit clears to ok;
    // the next one, one count above, trips a fault over.
    repeat (FAST_LEN) send_sample(0, 3000, 1'b1);
    repeat (FAST_LEN) send_sample(0, 3001, 1'b1);
    // The trip shows up on another channel, even on a skipped sample.
    send_sample(1, 100, 1'b0);
    // Five more full-scale negative samples close channel 2's fast window
    // with a fault under.
    repeat (FAST_LEN - 1) send_sample(2, -32768, 1'b1);

    run_random(140);

    // Moderate random limits.
    apply_limits(-int'($urandom_range(0, 8000)), int'($urandom_range(0, 8000)),
                 -int'($urandom_range(0, 8000)), int'($urandom_range(0, 8000)));
    run_random(120);

    // Widest band: no sample can leave it, so nothing moves any window.
    apply_limits(-32768, 32767, -32768, 32767);
    run_random(20);

    // Inverted extremes: every sample is out of band and every window faults.
    apply_limits(32767, -32768, 32767, -32768);
    run_random(80);

    // Default slow band with the widest fast band, so a fast verdict is always ok.
    apply_limits(int'(SLOW_UNDER_RST), int'(SLOW_OVER_RST), -32768, 32767);
    run_random(80);

    // A stretch with no idling on either side, with the long hold-off of the
    // result side in its middle so that the block fills and stalls its input.
    apply_limits(-int'($urandom_range(0, 4000)), int'($urandom_range(0, 4000)),
                 -int'($urandom_range(0, 6000)), int'($urandom_range(0, 6000)));
    sender_gaps   <= 1'b0;
    receiver_gaps <= 1'b0;
    run_random(60);
    hold_request  <= 1'b1;
    run_random(90);
    sender_gaps   <= 1'b1;
    receiver_gaps <= 1'b1;
    run_random(100);

    drain();
    repeat (6) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
